/* rtl/lpsht_pkg.sv */
// ----------------------------------------------------------------------------
// lpsht_pkg
// Types and constants shared by the string hash table modules.
// ----------------------------------------------------------------------------
package lpsht_pkg;

	localparam int TABLE_SLOTS = 512;
	localparam int KEY_CHARS   = 256;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CHAR_W      = $clog2(KEY_CHARS);
	localparam int LEN_W       = CHAR_W + 1;
	localparam int KADDR_W     = SLOT_W + CHAR_W;

	// slot marks
	localparam logic [1:0] MK_OCCUPIED = 2'd0;
	localparam logic [1:0] MK_EMPTY    = 2'd1;
	localparam logic [1:0] MK_DELETED  = 2'd2;

	// operations
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_ABSENT = 2'd3;

	// result codes
	localparam logic [2:0] RC_INSERTED  = 3'd0;
	localparam logic [2:0] RC_PRESENT   = 3'd1;
	localparam logic [2:0] RC_FOUND     = 3'd2;
	localparam logic [2:0] RC_NOT_FOUND = 3'd3;
	localparam logic [2:0] RC_DELETED   = 3'd4;
	localparam logic [2:0] RC_FULL      = 3'd5;
	localparam logic [2:0] RC_TOO_LONG  = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key_byte;
		logic       key_end;
	} req_t;

	typedef struct packed {
		logic [2:0]        code;
		logic [SLOT_W-1:0] slot;
		logic              absent;
	} rsp_t;

	// slot header: mark and key length
	typedef struct packed {
		logic [1:0]       mark;
		logic [LEN_W-1:0] len;
	} hdr_t;

endpackage

/* rtl/lpsht_ram.sv */
// ----------------------------------------------------------------------------
// lpsht_ram
// Generic single-port-write, one-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lpsht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/linear_probe_string_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_string_hash_table
// Open-addressing table of byte-string keys with linear probing.
// ----------------------------------------------------------------------------
// Usage: a key enters one byte per request (start high, busy low). The
// request with key_end set also carries op and runs the operation on the
// whole collected key; other requests give no result and leave busy low.
// Home slot is the byte sum modulo 512; the probe walks forward, wrapping.
// One result per ending request is shown on rsp for one cycle with done high;
// the receiver cannot stall it. Per probed slot the block reads the slot
// header and decides (states HRD, IRD, HCHK) and, for an Occupied slot of
// equal length, compares key bytes through the key store read port, one
// byte per CRD/CCHK state pair. A put that inserts then copies the key
// one byte per cycle. An ending request thus takes a data-dependent time:
// the header states per probed slot plus the compare and copy states and
// a closing DONE state, up to the full 512-slot walk.
// After reset, a clearing pass writes every slot header Empty with busy high.
// Keys longer than 255 bytes return code 6.
// ----------------------------------------------------------------------------
module linear_probe_string_hash_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lpsht_pkg::req_t   req,
	output logic              done,
	output lpsht_pkg::rsp_t   rsp
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_HRD   = 4'd2;
	localparam logic [3:0] ST_HCHK  = 4'd3;
	localparam logic [3:0] ST_CRD   = 4'd4;
	localparam logic [3:0] ST_CCHK  = 4'd5;
	localparam logic [3:0] ST_COPY  = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;
	localparam logic [3:0] ST_IRD   = 4'd8;

	localparam int SW = lpsht_pkg::SLOT_W;
	localparam int CW = lpsht_pkg::CHAR_W;
	localparam int LW = lpsht_pkg::LEN_W;

	logic [3:0]    state_q;
	logic [SW-1:0] ix_q;
	logic [SW:0]   n_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] klen_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] ci_q;
	logic [1:0]    op_q;
	lpsht_pkg::hdr_t hdr_q;
	lpsht_pkg::rsp_t rsp_q;
	logic          done_q;

	// header memory
	logic            h_we;
	logic [SW-1:0]   h_waddr;
	lpsht_pkg::hdr_t h_wdata, h_rdata;

	// incoming key memory
	logic          i_we;
	logic [CW-1:0] i_waddr, i_raddr;
	logic [7:0]    i_wdata, i_rdata;

	// stored key memory
	logic          k_we;
	logic [lpsht_pkg::KADDR_W-1:0] k_waddr, k_raddr;
	logic [7:0]    k_rdata;

	lpsht_ram #(.WIDTH($bits(lpsht_pkg::hdr_t)), .DEPTH(lpsht_pkg::TABLE_SLOTS)) u_hdr (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(ix_q), .rdata(h_rdata)
	);
	lpsht_ram #(.WIDTH(8), .DEPTH(lpsht_pkg::KEY_CHARS)) u_inkey (
		.clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
		.raddr(i_raddr), .rdata(i_rdata)
	);
	lpsht_ram #(.WIDTH(8), .DEPTH(lpsht_pkg::TABLE_SLOTS * lpsht_pkg::KEY_CHARS)) u_key (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(i_rdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// probe decisions on the fetched header
	logic occ, emp, cand;
	assign occ  = (hdr_q.mark == lpsht_pkg::MK_OCCUPIED);
	assign emp  = (hdr_q.mark == lpsht_pkg::MK_EMPTY);
	assign cand = occ && (hdr_q.len == len_q);

	logic last_slot;
	assign last_slot = (n_q == (SW+1)'(lpsht_pkg::TABLE_SLOTS - 1));

	logic bytes_eq;
	assign bytes_eq = (k_rdata == i_rdata);
	logic last_byte;
	assign last_byte = ({1'b0, ci_q} == len_q - LW'(1));

	// memory port control
	always_comb begin
		h_we    = 1'b0;
		h_waddr = ix_q;
		h_wdata = '{mark: lpsht_pkg::MK_EMPTY, len: '0};
		i_we    = accept && (klen_q < LW'(lpsht_pkg::KEY_CHARS - 1));
		i_waddr = klen_q[CW-1:0];
		i_wdata = req.key_byte;
		i_raddr = ci_q;
		k_we    = 1'b0;
		k_waddr = {ix_q, ci_q - CW'(1)};
		k_raddr = {ix_q, ci_q};
		unique case (state_q)
			ST_CLEAR: begin
				h_we = 1'b1;
			end
			ST_HCHK: begin
				if (op_q == lpsht_pkg::OP_PUT && !occ) begin
					h_we    = 1'b1;
					h_wdata = '{mark: lpsht_pkg::MK_OCCUPIED, len: len_q};
				end
			end
			ST_CCHK: begin
				if (bytes_eq && last_byte && op_q == lpsht_pkg::OP_DELETE) begin
					h_we    = 1'b1;
					h_wdata = '{mark: lpsht_pkg::MK_DELETED, len: '0};
				end
			end
			ST_COPY: begin
				k_we = (ci_q != '0);
			end
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ix_q    <= '0;
			n_q     <= '0;
			klen_q  <= '0;
			sum_q   <= '0;
			ci_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					ix_q <= ix_q + SW'(1);
					if (ix_q == SW'(lpsht_pkg::TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						logic [LW-1:0] nlen;
						logic [SW-1:0] nsum;
						nlen = klen_q;
						nsum = sum_q;
						if (klen_q < LW'(lpsht_pkg::KEY_CHARS - 1)) begin
							nlen = klen_q + LW'(1);
							nsum = sum_q + SW'(req.key_byte);
						end else begin
							nlen = LW'(lpsht_pkg::KEY_CHARS);
						end
						if (req.key_end) begin
							klen_q <= '0;
							sum_q  <= '0;
							len_q  <= nlen;
							op_q   <= req.op;
							ix_q   <= nsum;
							n_q    <= '0;
							if (nlen == LW'(lpsht_pkg::KEY_CHARS)) begin
								rsp_q   <= '{code: lpsht_pkg::RC_TOO_LONG, slot: '0,
									absent: 1'b0};
								state_q <= ST_DONE;
							end else begin
								rsp_q   <= '{code: lpsht_pkg::RC_NOT_FOUND, slot: '0,
									absent: 1'b0};
								state_q <= ST_HRD;
							end
						end else begin
							klen_q <= nlen;
							sum_q  <= nsum;
						end
					end
				end
				ST_HRD: begin
					state_q <= ST_IRD;
				end
				ST_IRD: begin
					hdr_q   <= h_rdata;
					ci_q    <= '0;
					state_q <= ST_HCHK;
				end
				ST_HCHK: begin
					priority if (op_q == lpsht_pkg::OP_PUT && !occ) begin
						rsp_q   <= '{code: lpsht_pkg::RC_INSERTED, slot: ix_q,
							absent: 1'b0};
						ci_q    <= '0;
						state_q <= ST_COPY;
					end else if (emp && (op_q == lpsht_pkg::OP_FIND
							|| op_q == lpsht_pkg::OP_ABSENT)) begin
						rsp_q.absent <= (op_q == lpsht_pkg::OP_ABSENT);
						state_q      <= ST_DONE;
					end else if (cand) begin
						state_q <= ST_CRD;
					end else if (last_slot) begin
						// no candidate here and the walk is over
						if (op_q == lpsht_pkg::OP_PUT) begin
							rsp_q.code <= lpsht_pkg::RC_FULL;
						end
						state_q <= ST_DONE;
					end else begin
						// no candidate here: step on
						ix_q    <= ix_q + SW'(1);
						n_q     <= n_q + (SW+1)'(1);
						state_q <= ST_HRD;
					end
				end
				ST_CRD: begin
					state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					if (bytes_eq && !last_byte) begin
						ci_q    <= ci_q + CW'(1);
						state_q <= ST_CRD;
					end else if (bytes_eq) begin
						unique case (op_q)
							lpsht_pkg::OP_PUT: begin
								rsp_q <= '{code: lpsht_pkg::RC_PRESENT, slot: ix_q,
									absent: 1'b0};
							end
							lpsht_pkg::OP_DELETE: begin
								rsp_q <= '{code: lpsht_pkg::RC_DELETED, slot: ix_q,
									absent: 1'b0};
							end
							default: begin
								rsp_q <= '{code: lpsht_pkg::RC_FOUND, slot: ix_q,
									absent: 1'b0};
							end
						endcase
						state_q <= ST_DONE;
					end else if (last_slot) begin
						if (op_q == lpsht_pkg::OP_PUT) begin
							rsp_q.code <= lpsht_pkg::RC_FULL;
						end
						state_q <= ST_DONE;
					end else begin
						ix_q    <= ix_q + SW'(1);
						n_q     <= n_q + (SW+1)'(1);
						state_q <= ST_HRD;
					end
				end
				ST_COPY: begin
					// read byte ci, write byte ci-1 in the cycle after
					if ({1'b0, ci_q} == len_q) begin
						state_q <= ST_DONE;
					end else begin
						ci_q <= ci_q + CW'(1);
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* verif/tb_linear_probe_string_hash_table.sv */
// ----------------------------------------------------------------------------
// tb_linear_probe_string_hash_table
// Self-checking bench for the linear-probe string hash table: keys are fed
// byte by byte through a gapped request driver, a bit-accurate table model
// predicts every result, and a monitor compares each done strobe in order.
// ----------------------------------------------------------------------------
module tb_linear_probe_string_hash_table;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = lpsht_pkg::SLOT_W;
	localparam int LW = lpsht_pkg::LEN_W;

	typedef logic [7:0] byte_q_t [$];

	typedef struct {
		lpsht_pkg::req_t r;
		int              gap;
		bit              sync;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	lpsht_pkg::req_t req = '0;
	lpsht_pkg::rsp_t rsp;

	linear_probe_string_hash_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// table model state
	logic [1:0]    tbl_mark [lpsht_pkg::TABLE_SLOTS];
	logic [LW-1:0] tbl_len  [lpsht_pkg::TABLE_SLOTS];
	logic [7:0]    tbl_chars [lpsht_pkg::TABLE_SLOTS][lpsht_pkg::KEY_CHARS];
	logic [7:0]    in_key [lpsht_pkg::KEY_CHARS];
	int            in_len;
	int            in_sum;

	pend_t           pending [$];
	lpsht_pkg::rsp_t want_rsp [$];
	int    errors = 0;
	int    n_results = 0;
	int    n_requests = 0;
	int    code_seen [8];
	bit    gaps_on;

	task automatic report(string what, int got, int exp);
		$display("mismatch %0d: %s got %0d expected %0d", n_results, what, got, exp);
		errors++;
	endtask

	function automatic bit key_hit(int ix, int len);
		if (tbl_mark[ix] != lpsht_pkg::MK_OCCUPIED || tbl_len[ix] != len) return 1'b0;
		for (int i = 0; i < len; i++)
			if (tbl_chars[ix][i] != in_key[i]) return 1'b0;
		return 1'b1;
	endfunction

	// apply one accepted request to the table model
	task automatic table_step(input lpsht_pkg::req_t r);
		int              len;
		int              home;
		int              ix;
		lpsht_pkg::rsp_t e;
		if (in_len < lpsht_pkg::KEY_CHARS - 1) begin
			in_key[in_len] = r.key_byte;
			in_len++;
			in_sum = (in_sum + r.key_byte) % lpsht_pkg::TABLE_SLOTS;
		end else begin
			in_len = lpsht_pkg::KEY_CHARS;
		end
		if (!r.key_end) return;
		len = in_len;
		home = in_sum;
		in_len = 0;
		in_sum = 0;
		e.code = lpsht_pkg::RC_NOT_FOUND;
		e.slot = '0;
		e.absent = 1'b0;
		if (len >= lpsht_pkg::KEY_CHARS) begin
			e.code = lpsht_pkg::RC_TOO_LONG;
		end else if (r.op == lpsht_pkg::OP_PUT) begin
			e.code = lpsht_pkg::RC_FULL;
			for (int n = 0; n < lpsht_pkg::TABLE_SLOTS; n++) begin
				ix = (home + n) % lpsht_pkg::TABLE_SLOTS;
				if (tbl_mark[ix] != lpsht_pkg::MK_OCCUPIED) begin
					for (int i = 0; i < len; i++) tbl_chars[ix][i] = in_key[i];
					tbl_len[ix] = LW'(len);
					tbl_mark[ix] = lpsht_pkg::MK_OCCUPIED;
					e.code = lpsht_pkg::RC_INSERTED;
					e.slot = SW'(ix);
					break;
				end
				if (key_hit(ix, len)) begin
					e.code = lpsht_pkg::RC_PRESENT;
					e.slot = SW'(ix);
					break;
				end
			end
		end else if (r.op == lpsht_pkg::OP_FIND) begin
			for (int n = 0; n < lpsht_pkg::TABLE_SLOTS; n++) begin
				ix = (home + n) % lpsht_pkg::TABLE_SLOTS;
				if (tbl_mark[ix] == lpsht_pkg::MK_EMPTY) break;
				if (key_hit(ix, len)) begin
					e.code = lpsht_pkg::RC_FOUND;
					e.slot = SW'(ix);
					break;
				end
			end
		end else if (r.op == lpsht_pkg::OP_DELETE) begin
			for (int n = 0; n < lpsht_pkg::TABLE_SLOTS; n++) begin
				ix = (home + n) % lpsht_pkg::TABLE_SLOTS;
				if (key_hit(ix, len)) begin
					tbl_mark[ix] = lpsht_pkg::MK_DELETED;
					tbl_len[ix] = '0;
					e.code = lpsht_pkg::RC_DELETED;
					e.slot = SW'(ix);
					break;
				end
			end
		end else begin
			for (int n = 0; n < lpsht_pkg::TABLE_SLOTS; n++) begin
				ix = (home + n) % lpsht_pkg::TABLE_SLOTS;
				if (tbl_mark[ix] == lpsht_pkg::MK_EMPTY) begin
					e.absent = 1'b1;
					break;
				end
				if (key_hit(ix, len)) begin
					e.code = lpsht_pkg::RC_FOUND;
					e.slot = SW'(ix);
					break;
				end
			end
		end
		want_rsp.push_back(e);
	endtask

	// queue one key as a run of byte requests, op on the last byte
	task automatic send_key(input byte_q_t k, input logic [1:0] op, input bit sync = 0);
		pend_t p;
		foreach (k[i]) begin
			p.r.key_byte = k[i];
			p.r.key_end = (i == k.size() - 1);
			p.r.op = p.r.key_end ? op : 2'($urandom_range(0, 3));
			p.gap = gaps_on ? $urandom_range(0, 6) : 0;
			p.sync = sync && (i == 0);
			pending.push_back(p);
		end
	endtask

	function automatic byte_q_t rand_key(int maxlen);
		byte_q_t k;
		int n;
		n = $urandom_range(1, maxlen);
		for (int i = 0; i < n; i++) k.push_back(8'($urandom_range(0, 255)));
		return k;
	endfunction

	// request driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		bit nstart;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			nstart = start;
			if (start && !busy) begin
				table_step(req);
				n_requests++;
				void'(pending.pop_front());
				nstart = 1'b0;
				if (pending.size() != 0) gap_left = pending[0].gap;
			end
			if (!nstart && pending.size() != 0) begin
				if (pending[0].sync && want_rsp.size() != 0) begin
					gap_left = pending[0].gap;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					req <= pending[0].r;
					nstart = 1'b1;
				end
			end
			start <= nstart;
		end
	end

	// result monitor
	always @(posedge clk) begin
		lpsht_pkg::rsp_t e;
		if (arst_n && done) begin
			n_results++;
			if (want_rsp.size() == 0) begin
				report("unexpected result, code", rsp.code, -1);
			end else begin
				e = want_rsp.pop_front();
				code_seen[e.code]++;
				if (rsp.code !== e.code) report("code", rsp.code, e.code);
				if (rsp.slot !== e.slot) report("slot", rsp.slot, e.slot);
				if (rsp.absent !== e.absent) report("absent", rsp.absent, e.absent);
			end
		end
	end

	// stimulus
	initial begin
		byte_q_t pool [24];
		byte_q_t k;
		int r;
		for (int i = 0; i < lpsht_pkg::TABLE_SLOTS; i++) begin
			tbl_mark[i] = lpsht_pkg::MK_EMPTY;
			tbl_len[i] = '0;
		end
		in_len = 0;
		in_sum = 0;
		gaps_on = 1'b1;

		// directed: zero byte, max byte, collisions, every op
		send_key('{8'h00}, lpsht_pkg::OP_PUT);
		send_key('{8'hff}, lpsht_pkg::OP_PUT);
		send_key('{8'hff, 8'h01}, lpsht_pkg::OP_PUT);
		send_key('{8'h01, 8'hff}, lpsht_pkg::OP_PUT);
		send_key('{8'h01, 8'hff}, lpsht_pkg::OP_FIND);
		send_key('{8'hff}, lpsht_pkg::OP_PUT);
		send_key('{8'h00}, lpsht_pkg::OP_FIND);
		send_key('{8'h01}, lpsht_pkg::OP_FIND);
		send_key('{8'h01}, lpsht_pkg::OP_ABSENT);
		send_key('{8'h00}, lpsht_pkg::OP_ABSENT);
		send_key('{8'h00}, lpsht_pkg::OP_DELETE);
		send_key('{8'h00}, lpsht_pkg::OP_DELETE);
		send_key('{8'h00}, lpsht_pkg::OP_FIND);
		send_key('{8'hff, 8'h01}, lpsht_pkg::OP_DELETE);
		send_key('{8'h01, 8'hff}, lpsht_pkg::OP_ABSENT);
		send_key('{8'h00, 8'h00}, lpsht_pkg::OP_PUT, 1);
		// one byte past the longest legal key
		k = {};
		for (int i = 0; i < lpsht_pkg::KEY_CHARS - 1; i++)
			k.push_back(8'($urandom_range(0, 255)));
		k.push_back(8'h5a);
		send_key(k, lpsht_pkg::OP_PUT);
		send_key('{8'h00, 8'h00}, lpsht_pkg::OP_ABSENT);

		// random: mostly a small key pool so ops hit each other
		foreach (pool[i]) pool[i] = rand_key(4);
		for (int n = 0; n < 50; n++) begin
			if (n % 15 == 0) gaps_on = $urandom_range(0, 2) != 0;
			r = $urandom_range(0, 9);
			k = (r == 0) ? rand_key(4) : pool[$urandom_range(0, 23)];
			send_key(k, 2'($urandom_range(0, 3)), n == 25);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// drain and let the last walk settle
		wait (pending.size() == 0 && want_rsp.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d requests, %0d results: inserted %0d present %0d found %0d",
			n_requests, n_results, code_seen[lpsht_pkg::RC_INSERTED],
			code_seen[lpsht_pkg::RC_PRESENT], code_seen[lpsht_pkg::RC_FOUND]);
		$display("not found %0d deleted %0d full %0d too long %0d",
			code_seen[lpsht_pkg::RC_NOT_FOUND], code_seen[lpsht_pkg::RC_DELETED],
			code_seen[lpsht_pkg::RC_FULL], code_seen[lpsht_pkg::RC_TOO_LONG]);
		if (errors == 0 && want_rsp.size() == 0) begin
			$display("linear_probe_string_hash_table regression: pass");
		end else begin
			$display("linear_probe_string_hash_table regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("timeout with %0d requests pending", pending.size());
		$display("linear_probe_string_hash_table regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/lpsht_pkg.sv
rtl/lpsht_ram.sv
rtl/linear_probe_string_hash_table.sv
verif/tb_linear_probe_string_hash_table.sv
